// ===== src/lpfr_pkg.sv =====
// Shared types and constants for the length-prefixed frame receiver.
// Holds the parser state encoding, item action codes and control characters.
// Depends on nothing.
`timescale 1ns / 1ps

package lpfr_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

    // Control characters of the frame format
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_READ    = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PENDING = 3'd1,
        ST_SOH     = 3'd2,
        ST_LEN     = 3'd3,
        ST_TEXT    = 3'd4,
        ST_TEXTEND = 3'd5,
        ST_ETX     = 3'd6
    } t_parse_state;

endpackage

// ===== src/length_prefixed_frame_receiver.sv =====
// Top level of the length-prefixed frame receiver: parser, payload memory
// and result register. Depends on lpfr_pkg.
`timescale 1ns / 1ps

// Master-side receiver for SOH / length / STX / payload / ETX / EOT frames.
// Each input transaction carries an action in tuser: a received serial byte,
// a data request, or a read of a stored payload byte. A request is honored
// only while idle; it pulses interrupt_pulse in its result, clears the
// announced length and the received count and arms the parser. The parser
// waits for SOH, takes the next byte as the payload length, waits for STX,
// stores payload bytes until the count reaches the length (a length of 0
// means 256 bytes), then waits for ETX and EOT and returns to idle. Bytes
// that are not the awaited control character are dropped, as are requests
// while busy and the unused action code. Reads at or beyond the received
// count return 0. Every input transaction yields exactly one result
// transaction carrying the state after the update. The block accepts one
// transaction per clock cycle while the result stage is empty or drained;
// each result is registered and appears in the cycle after its input is
// accepted. The payload memory is not cleared after reset: reads are
// gated by the received count, so only bytes of the current frame come back.
module length_prefixed_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  logic [1:0]  i_s_tuser,   // [1:0] action
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [0] idle, [3:1] frame_state,
                                     // [11:4] message_length,
                                     // [19:12] received_count,
                                     // [20] interrupt_pulse, [21] byte_stored,
                                     // [29:22] read_data, [31:30] zero
);

    // ---------------------------------------------------------------
    // Frame state registers
    // ---------------------------------------------------------------
    lpfr_pkg::t_parse_state r_state, n_state;
    logic [7:0]             r_length, n_length;
    logic [7:0]             r_count, n_count;

    // Payload memory: one write port, one registered read port
    logic [7:0] r_mem [lpfr_pkg::PAYLOAD_DEPTH];
    logic [7:0] r_mem_q;

    // Result stage
    logic                   r_s1_valid;
    lpfr_pkg::t_parse_state r_s1_state;
    logic [7:0]             r_s1_length;
    logic [7:0]             r_s1_count;
    logic                   r_s1_pulse;
    logic                   r_s1_stored;
    logic                   r_s1_rd_en;

    // Input unpacking and handshake
    lpfr_pkg::t_action w_action;
    logic [7:0]        w_rx_byte;
    logic [7:0]        w_read_index;
    logic              w_accept;
    logic              w_advance;

    // Per-transaction control
    logic w_pulse;
    logic w_wr_en;
    logic w_rd_en;

    assign w_action     = lpfr_pkg::t_action'(i_s_tuser);
    assign w_rx_byte    = i_s_tdata[7:0];
    assign w_read_index = i_s_tdata[15:8];

    // Advance the result stage whenever it is empty or being drained
    assign w_advance  = !r_s1_valid || i_m_tready;
    assign o_s_tready = w_advance;
    assign w_accept   = i_s_tvalid && w_advance;

    // ---------------------------------------------------------------
    // Next-state logic of the parser
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_length = r_length;
        n_count  = r_count;
        if (w_accept) begin
            case (w_action)
                lpfr_pkg::ACT_BYTE: begin
                    case (r_state)
                        lpfr_pkg::ST_PENDING: begin
                            if (w_rx_byte == lpfr_pkg::CH_SOH) begin
                                n_state = lpfr_pkg::ST_SOH;
                            end
                        end
                        lpfr_pkg::ST_SOH: begin
                            n_length = w_rx_byte;
                            n_state  = lpfr_pkg::ST_LEN;
                        end
                        lpfr_pkg::ST_LEN: begin
                            if (w_rx_byte == lpfr_pkg::CH_STX) begin
                                n_state = lpfr_pkg::ST_TEXT;
                            end
                        end
                        lpfr_pkg::ST_TEXT: begin
                            // 8-bit count wraps, so a length of 0 ends after 256 bytes
                            n_count = r_count + 8'd1;
                            if (n_count == r_length) begin
                                n_state = lpfr_pkg::ST_TEXTEND;
                            end
                        end
                        lpfr_pkg::ST_TEXTEND: begin
                            if (w_rx_byte == lpfr_pkg::CH_ETX) begin
                                n_state = lpfr_pkg::ST_ETX;
                            end
                        end
                        lpfr_pkg::ST_ETX: begin
                            if (w_rx_byte == lpfr_pkg::CH_EOT) begin
                                n_state = lpfr_pkg::ST_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                lpfr_pkg::ACT_REQUEST: begin
                    if (r_state == lpfr_pkg::ST_IDLE) begin
                        n_state  = lpfr_pkg::ST_PENDING;
                        n_length = 8'd0;
                        n_count  = 8'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Output decode: memory strobes and result flags
    // ---------------------------------------------------------------
    always_comb begin
        w_pulse = 1'b0;
        w_wr_en = 1'b0;
        w_rd_en = 1'b0;
        if (w_accept) begin
            case (w_action)
                lpfr_pkg::ACT_BYTE: begin
                    // drop payload bytes that fall beyond the store
                    w_wr_en = (r_state == lpfr_pkg::ST_TEXT)
                              && ({1'b0, r_count} < 9'(lpfr_pkg::PAYLOAD_DEPTH));
                end
                lpfr_pkg::ACT_REQUEST: begin
                    w_pulse = (r_state == lpfr_pkg::ST_IDLE);
                end
                lpfr_pkg::ACT_READ: begin
                    // positions at or beyond the count read as the terminator
                    w_rd_en = (w_read_index < r_count)
                              && ({1'b0, w_read_index} < 9'(lpfr_pkg::PAYLOAD_DEPTH));
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lpfr_pkg::ST_IDLE;
            r_length   <= 8'd0;
            r_count    <= 8'd0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_length <= n_length;
            r_count  <= n_count;
            if (w_advance) begin
                r_s1_valid <= i_s_tvalid;
            end
        end
    end

    // Result payload: load only when the stage advances, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_state  <= n_state;
            r_s1_length <= n_length;
            r_s1_count  <= n_count;
            r_s1_pulse  <= w_pulse;
            r_s1_stored <= w_wr_en;
            r_s1_rd_en  <= w_rd_en;
        end
    end

    // Payload memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[lpfr_pkg::ADDR_W-1:0]] <= w_rx_byte;
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[w_read_index[lpfr_pkg::ADDR_W-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // Result packing
    // ---------------------------------------------------------------
    assign o_m_tvalid = r_s1_valid;
    assign o_m_tdata  = {2'b00,
                         (r_s1_rd_en ? r_mem_q : 8'd0),
                         r_s1_stored,
                         r_s1_pulse,
                         r_s1_count,
                         r_s1_length,
                         r_s1_state,
                         (r_s1_state == lpfr_pkg::ST_IDLE)};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_store_only_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == lpfr_pkg::ST_TEXT))
        else $error("payload write outside the payload phase");

    a_request_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_action == lpfr_pkg::ACT_REQUEST && r_state == lpfr_pkg::ST_IDLE)
        |=> (r_state == lpfr_pkg::ST_PENDING && r_count == 8'd0 && r_length == 8'd0))
        else $error("accepted request did not arm the parser");

    a_pulse_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_pulse) |-> (r_s1_state == lpfr_pkg::ST_PENDING))
        else $error("interrupt pulse without pending state");

    a_read_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (r_state != lpfr_pkg::ST_PENDING || r_count == 8'd0) && !w_wr_en)
        else $error("payload read and write in one transaction");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the length-prefixed frame receiver.
// Drives directed and random frame traffic and checks every result against
// a cycle-free predictor of the parser. Depends on lpfr_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;

    // Action code that the block must ignore; it has no member in the package
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    // Result transaction layout, most significant field first
    typedef struct packed {
        logic [1:0] pad;
        logic [7:0] read_data;
        logic       byte_stored;
        logic       interrupt_pulse;
        logic [7:0] received_count;
        logic [7:0] message_length;
        logic [2:0] frame_state;
        logic       idle;
    } t_frame_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;    // [7:0] rx_byte, [15:8] read_index
    logic [1:0]  i_s_tuser  = '0;    // [1:0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;          // [0] idle, [3:1] frame_state,
                                     // [11:4] message_length,
                                     // [19:12] received_count,
                                     // [20] interrupt_pulse, [21] byte_stored,
                                     // [29:22] read_data, [31:30] zero

    length_prefixed_frame_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted parser state, updated once per accepted input transaction
    lpfr_pkg::t_parse_state frame_phase   = lpfr_pkg::ST_IDLE;
    logic [7:0]             announced_len = '0;
    logic [7:0]             payload_count = '0;
    logic [7:0]             payload_mem [lpfr_pkg::PAYLOAD_DEPTH];

    t_frame_result pending_results [$];
    t_frame_result result_want;
    t_frame_result result_got;

    int mismatch_count     = 0;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // Apply one input transaction to the predicted state and return the
    // result the block must produce for it.
    function automatic t_frame_result advance_parser(input logic [1:0] action,
                                                     input logic [7:0] rx_byte,
                                                     input logic [7:0] read_index);
        t_frame_result r;
        r = '0;
        case (action)
            lpfr_pkg::ACT_BYTE: begin
                case (frame_phase)
                    lpfr_pkg::ST_PENDING: begin
                        if (rx_byte == lpfr_pkg::CH_SOH) frame_phase = lpfr_pkg::ST_SOH;
                    end
                    lpfr_pkg::ST_SOH: begin
                        announced_len = rx_byte;
                        frame_phase   = lpfr_pkg::ST_LEN;
                    end
                    lpfr_pkg::ST_LEN: begin
                        if (rx_byte == lpfr_pkg::CH_STX) frame_phase = lpfr_pkg::ST_TEXT;
                    end
                    lpfr_pkg::ST_TEXT: begin
                        // Count every payload byte, store only what fits
                        if (int'(payload_count) < lpfr_pkg::PAYLOAD_DEPTH) begin
                            payload_mem[payload_count] = rx_byte;
                            r.byte_stored = 1'b1;
                        end
                        payload_count = payload_count + 8'd1;
                        if (payload_count == announced_len) begin
                            frame_phase = lpfr_pkg::ST_TEXTEND;
                        end
                    end
                    lpfr_pkg::ST_TEXTEND: begin
                        if (rx_byte == lpfr_pkg::CH_ETX) frame_phase = lpfr_pkg::ST_ETX;
                    end
                    lpfr_pkg::ST_ETX: begin
                        if (rx_byte == lpfr_pkg::CH_EOT) frame_phase = lpfr_pkg::ST_IDLE;
                    end
                    default: ;
                endcase
            end
            lpfr_pkg::ACT_REQUEST: begin
                if (frame_phase == lpfr_pkg::ST_IDLE) begin
                    frame_phase       = lpfr_pkg::ST_PENDING;
                    announced_len     = '0;
                    payload_count     = '0;
                    r.interrupt_pulse = 1'b1;
                end
            end
            lpfr_pkg::ACT_READ: begin
                // At or past the count the terminator comes back
                if (read_index < payload_count
                    && int'(read_index) < lpfr_pkg::PAYLOAD_DEPTH)
                    r.read_data = payload_mem[read_index];
            end
            default: ;
        endcase
        r.idle           = (frame_phase == lpfr_pkg::ST_IDLE);
        r.frame_state    = frame_phase;
        r.message_length = announced_len;
        r.received_count = payload_count;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endtask

    // Result checker: take each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            result_got = o_m_tdata;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result expected none actual %h",
                         $time, result_got);
            end else begin
                result_want = pending_results.pop_front();
                compare_field("idle", 8'(result_want.idle), 8'(result_got.idle));
                compare_field("frame_state", 8'(result_want.frame_state),
                              8'(result_got.frame_state));
                compare_field("message_length", result_want.message_length,
                              result_got.message_length);
                compare_field("received_count", result_want.received_count,
                              result_got.received_count);
                compare_field("interrupt_pulse", 8'(result_want.interrupt_pulse),
                              8'(result_got.interrupt_pulse));
                compare_field("byte_stored", 8'(result_want.byte_stored),
                              8'(result_got.byte_stored));
                compare_field("read_data", result_want.read_data, result_got.read_data);
                compare_field("pad", 8'(result_want.pad), 8'(result_got.pad));
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send one input transaction, idling the sender for random cycles ahead
    // of it. Valid stays high on return; a drain or a sender idle lowers it.
    task automatic send_item(input logic [1:0] action, input logic [7:0] rx_byte,
                             input logic [7:0] read_index);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= action;
        i_s_tdata  <= {read_index, rx_byte};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(advance_parser(action, rx_byte, read_index));
    endtask

    // Hold the input side quiet until every predicted result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One short frame walked through every phase, with ignored bytes at each
    // control-character wait, a busy request, the unused code and edge reads.
    task automatic test_control_sequence();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(lpfr_pkg::ACT_READ, 8'h00, 8'h00);       // read while idle and empty
        send_item(lpfr_pkg::ACT_BYTE, 8'hFF, 8'h00);       // byte while idle: drop
        send_item(ACT_UNUSED, 8'hFF, 8'hFF);               // unused code: drop
        send_item(lpfr_pkg::ACT_REQUEST, 8'h00, 8'h00);    // arm, pulse the interrupt
        send_item(lpfr_pkg::ACT_REQUEST, 8'h00, 8'h00);    // busy request: drop
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_STX, 8'h00);  // not SOH: drop
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_SOH, 8'h00);
        send_item(lpfr_pkg::ACT_BYTE, 8'h03, 8'h00);       // length three
        send_item(lpfr_pkg::ACT_BYTE, 8'hAA, 8'h00);       // not STX: drop
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_STX, 8'h00);
        send_item(lpfr_pkg::ACT_BYTE, 8'hFF, 8'h00);
        send_item(lpfr_pkg::ACT_READ, 8'h00, 8'h00);       // inside the count
        send_item(lpfr_pkg::ACT_READ, 8'h00, 8'h01);       // at the count
        send_item(lpfr_pkg::ACT_BYTE, 8'h00, 8'h00);
        send_item(lpfr_pkg::ACT_BYTE, 8'h80, 8'h00);       // last payload byte
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_EOT, 8'h00);  // not ETX: drop
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_ETX, 8'h00);
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_SOH, 8'h00);  // not EOT: drop
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_EOT, 8'h00);  // back to idle
        send_item(lpfr_pkg::ACT_READ, 8'h00, 8'h02);
        send_item(lpfr_pkg::ACT_READ, 8'h00, 8'h03);       // at the count: terminator
        send_item(lpfr_pkg::ACT_READ, 8'h00, 8'hFF);       // far beyond the count
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_SOH, 8'h00);  // SOH while idle: drop
        drain_results();
    endtask

    // Length byte of zero: 256 payload bytes, after which the count wraps
    // and every read returns the terminator.
    task automatic test_full_length_frame();
        int i;
        send_item(lpfr_pkg::ACT_REQUEST, 8'h00, 8'h00);
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_SOH, 8'h00);
        send_item(lpfr_pkg::ACT_BYTE, 8'h00, 8'h00);
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_STX, 8'h00);
        for (i = 0; i < 256; i++) begin
            send_item(lpfr_pkg::ACT_BYTE, 8'($urandom_range(255)), 8'h00);
            if (i % 64 == 63) begin
                send_item(lpfr_pkg::ACT_READ, 8'h00, 8'($urandom_range(i + 1)));
            end
        end
        send_item(lpfr_pkg::ACT_READ, 8'h00, 8'h00);
        send_item(lpfr_pkg::ACT_READ, 8'h00, 8'hFF);
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_ETX, 8'h00);
        send_item(lpfr_pkg::ACT_BYTE, lpfr_pkg::CH_EOT, 8'h00);
        drain_results();
    endtask

    // Mostly well-formed frames with random lengths and payload, salted with
    // reads, stray bytes, busy requests and the unused code. Pause once in
    // the middle until the result queue is empty.
    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int goal);
        int         useful;
        int         sel;
        bit         paused;
        logic [1:0] act;
        logic [7:0] rx;
        logic [7:0] idx;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        useful = 0;
        paused = 1'b0;
        while (useful < goal) begin
            act = lpfr_pkg::ACT_BYTE;
            rx  = 8'($urandom_range(255));
            idx = 8'($urandom_range(255));
            if ($urandom_range(99) < 12) begin
                // Noise: any action, bytes often near the control characters
                act = 2'($urandom_range(ACT_UNUSED));
                if ($urandom_range(1) == 1) rx = 8'($urandom_range(lpfr_pkg::CH_EOT));
            end else begin
                useful++;
                if (payload_count != 0 && $urandom_range(99) < 15) begin
                    act = lpfr_pkg::ACT_READ;
                    idx = 8'($urandom_range(payload_count));
                end else begin
                    case (frame_phase)
                        lpfr_pkg::ST_IDLE:    act = lpfr_pkg::ACT_REQUEST;
                        lpfr_pkg::ST_PENDING: rx  = lpfr_pkg::CH_SOH;
                        lpfr_pkg::ST_SOH: begin
                            // Favor short payloads, keep some long and some 256
                            sel = $urandom_range(99);
                            if (sel < 70)      rx = 8'($urandom_range(1, 8));
                            else if (sel < 90) rx = 8'($urandom_range(9, 40));
                            else if (sel < 98) rx = 8'($urandom_range(41, 255));
                            else               rx = 8'h00;
                        end
                        lpfr_pkg::ST_LEN:     rx = lpfr_pkg::CH_STX;
                        lpfr_pkg::ST_TEXTEND: rx = lpfr_pkg::CH_ETX;
                        lpfr_pkg::ST_ETX:     rx = lpfr_pkg::CH_EOT;
                        default: ;  // payload byte stays random
                    endcase
                end
            end
            send_item(act, rx, idx);
            if (!paused && useful >= goal / 2) begin
                paused = 1'b1;
                drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_control_sequence();
        test_full_length_frame();
        test_random_frames(0, 0, 170);
        test_random_frames(75, 0, 170);
        test_random_frames(0, 75, 170);
        test_random_frames(23, 23, 170);

        // Let any stray late result show up before the verdict
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
